/* src/char_lcd_nibble_write_sequencer_unit_defines.svh */
// Assertion macros shared by the checker of the LCD nibble write sequencer.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_UNIT_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_UNIT_DEFINES_SVH

// Concurrent assertion on the rising clock edge, off while reset is high.
`define LCDNW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion that also holds while reset is high.
`define LCDNW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/lcdnw_pkg.sv */
// Package with the types, constants and init table of the LCD nibble write sequencer.
`timescale 1ns / 1ps

package lcdnw_pkg;

  localparam int LCDNW_TIMER_WIDTH = 16;
  localparam int LCDNW_INIT_COUNT  = 5;

  localparam logic [7:0]  PULSE_RESET   = 8'd15;
  localparam logic [9:0]  GAP_RESET     = 10'd50;
  localparam logic [15:0] SETTLE_RESET  = 16'd1000;
  localparam logic [15:0] POWERUP_RESET = 16'd6000;

  typedef enum logic [1:0] {
    REG_PULSE_WIDTH  = 2'd0,
    REG_NIBBLE_GAP   = 2'd1,
    REG_BYTE_SETTLE  = 2'd2,
    REG_POWERUP      = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_POWERUP = 3'd0,
    PH_PULSE   = 3'd1,
    PH_GAP     = 3'd2,
    PH_SETTLE  = 3'd3,
    PH_IDLE    = 3'd4
  } phase_t;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_WRITE = 1'b1
  } command_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       rs;
    command_t   command;
  } item_t;

  typedef struct packed {
    logic [7:0]  pulse_width_ticks;
    logic [9:0]  nibble_gap_ticks;
    logic [15:0] byte_settle_ticks;
    logic [15:0] powerup_ticks;
  } cfg_t;

  function automatic logic [7:0] init_cmd(input logic [2:0] step);
    logic [7:0] cmd;
    case (step)
      3'd0:    cmd = 8'h02;
      3'd1:    cmd = 8'h28;
      3'd2:    cmd = 8'h0E;
      3'd3:    cmd = 8'h01;
      3'd4:    cmd = 8'h80;
      default: cmd = 8'h0F;
    endcase
    return cmd;
  endfunction

endpackage

/* src/lcdnw_cfg_regs.sv */
// Timing configuration registers of the LCD nibble write sequencer.
`timescale 1ns / 1ps

module lcdnw_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output lcdnw_pkg::cfg_t   cfg
);
  import lcdnw_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_width_ticks <= PULSE_RESET;
      cfg.nibble_gap_ticks  <= GAP_RESET;
      cfg.byte_settle_ticks <= SETTLE_RESET;
      cfg.powerup_ticks     <= POWERUP_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_PULSE_WIDTH: cfg.pulse_width_ticks <= cfg_data[7:0];
        REG_NIBBLE_GAP:  cfg.nibble_gap_ticks  <= cfg_data[9:0];
        REG_BYTE_SETTLE: cfg.byte_settle_ticks <= cfg_data;
        REG_POWERUP:     cfg.powerup_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* src/lcdnw_in_stage.sv */
// Input register that holds one request until the sequencer takes it.
`timescale 1ns / 1ps

module lcdnw_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lcdnw_pkg::item_t  in_item,
  output logic              item_valid,
  output lcdnw_pkg::item_t  item,
  input  logic              item_take
);
  import lcdnw_pkg::*;

  assign in_ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

/* src/lcdnw_seq.sv */
// Phase sequencer with wait timer, pin levels and result register.
`timescale 1ns / 1ps

module lcdnw_seq #(
  parameter int TIMER_WIDTH = lcdnw_pkg::LCDNW_TIMER_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  lcdnw_pkg::cfg_t   cfg,
  input  logic              item_valid,
  input  lcdnw_pkg::item_t  item,
  output logic              item_take,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [7:0]        res_data
);
  import lcdnw_pkg::*;

  localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  phase_t                 phase, phase_next;
  logic [TIMER_WIDTH-1:0] wait_counter, wait_counter_next;
  logic [7:0]             held_byte, held_byte_next;
  logic                   held_rs, held_rs_next;
  logic                   nibble_index, nibble_index_next;
  logic [2:0]             init_step, init_step_next;
  logic                   pin_rs, pin_rs_next;
  logic                   pin_en, pin_en_next;
  logic [3:0]             pin_nib, pin_nib_next;
  logic                   accepted_next;

  logic [TIMER_WIDTH-1:0] count_inc;
  logic [15:0]            limit;
  logic                   wait_done;
  logic [2:0]             step_inc;
  logic [7:0]             first_cmd;
  logic [7:0]             step_cmd;

  assign item_take = item_valid && (!res_valid || res_ready);

  assign count_inc = (wait_counter == TIMER_MAX) ? wait_counter : wait_counter + 1'b1;
  assign step_inc  = init_step + 3'd1;
  assign first_cmd = init_cmd(3'd0);
  assign step_cmd  = init_cmd(step_inc);

  always_comb begin
    case (phase)
      PH_POWERUP: limit = cfg.powerup_ticks;
      PH_PULSE:   limit = 16'(cfg.pulse_width_ticks);
      PH_GAP:     limit = 16'(cfg.nibble_gap_ticks);
      PH_SETTLE:  limit = cfg.byte_settle_ticks;
      default:    limit = cfg.byte_settle_ticks;
    endcase
  end

  // A limit beyond the counter's range ends the wait once the counter saturates.
  assign wait_done = (CMP_W'(count_inc) >= CMP_W'(limit)) || (count_inc == TIMER_MAX);

  always_comb begin
    phase_next        = phase;
    wait_counter_next = wait_counter;
    held_byte_next    = held_byte;
    held_rs_next      = held_rs;
    nibble_index_next = nibble_index;
    init_step_next    = init_step;
    pin_rs_next       = pin_rs;
    pin_en_next       = pin_en;
    pin_nib_next      = pin_nib;
    accepted_next     = 1'b0;

    if (item.command == CMD_WRITE) begin
      if (phase == PH_IDLE) begin
        held_rs_next      = item.rs;
        held_byte_next    = item.byte_value;
        nibble_index_next = 1'b0;
        pin_rs_next       = item.rs;
        pin_en_next       = 1'b1;
        pin_nib_next      = item.byte_value[7:4];
        phase_next        = PH_PULSE;
        wait_counter_next = '0;
        accepted_next     = 1'b1;
      end
    end else begin
      case (phase)
        PH_POWERUP: begin
          wait_counter_next = count_inc;
          if (wait_done) begin
            init_step_next    = 3'd0;
            held_rs_next      = 1'b0;
            held_byte_next    = first_cmd;
            nibble_index_next = 1'b0;
            pin_rs_next       = 1'b0;
            pin_en_next       = 1'b1;
            pin_nib_next      = first_cmd[7:4];
            phase_next        = PH_PULSE;
            wait_counter_next = '0;
          end
        end
        PH_PULSE: begin
          wait_counter_next = count_inc;
          if (wait_done) begin
            pin_en_next       = 1'b0;
            phase_next        = PH_GAP;
            wait_counter_next = '0;
          end
        end
        PH_GAP: begin
          wait_counter_next = count_inc;
          if (wait_done) begin
            wait_counter_next = '0;
            if (!nibble_index) begin
              nibble_index_next = 1'b1;
              pin_rs_next       = held_rs;
              pin_en_next       = 1'b1;
              pin_nib_next      = held_byte[3:0];
              phase_next        = PH_PULSE;
            end else begin
              phase_next = PH_SETTLE;
            end
          end
        end
        PH_SETTLE: begin
          wait_counter_next = count_inc;
          if (wait_done) begin
            wait_counter_next = '0;
            phase_next        = PH_IDLE;
            if (init_step < 3'(LCDNW_INIT_COUNT)) begin
              init_step_next = step_inc;
              if (step_inc < 3'(LCDNW_INIT_COUNT)) begin
                held_rs_next      = 1'b0;
                held_byte_next    = step_cmd;
                nibble_index_next = 1'b0;
                pin_rs_next       = 1'b0;
                pin_en_next       = 1'b1;
                pin_nib_next      = step_cmd[7:4];
                phase_next        = PH_PULSE;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_POWERUP;
      wait_counter <= '0;
      held_byte    <= '0;
      held_rs      <= 1'b0;
      nibble_index <= 1'b0;
      init_step    <= '0;
      pin_rs       <= 1'b0;
      pin_en       <= 1'b0;
      pin_nib      <= '0;
    end else if (item_take) begin
      phase        <= phase_next;
      wait_counter <= wait_counter_next;
      held_byte    <= held_byte_next;
      held_rs      <= held_rs_next;
      nibble_index <= nibble_index_next;
      init_step    <= init_step_next;
      pin_rs       <= pin_rs_next;
      pin_en       <= pin_en_next;
      pin_nib      <= pin_nib_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (item_take) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      res_data <= {accepted_next, phase_next != PH_IDLE, pin_nib_next, pin_en_next,
                   pin_rs_next};
    end
  end

endmodule

/* src/char_lcd_nibble_write_sequencer_unit.sv */
// Top level of the four-bit character LCD write sequencer.
`timescale 1ns / 1ps

// Each request is either one microsecond tick or a byte write; every request gives
// exactly one result with the RS, enable and DB4..DB7 levels, the busy flag and whether
// a write was accepted. One request is taken every clock cycle unless a result is stalled
// by m_axis_tready low; a request passes the input register and its result the result
// register, and the phase and timer update keeps that rate. After reset the block
// counts powerup_ticks ticks, then sends 0x02, 0x28, 0x0E, 0x01 and 0x80 on its own;
// write requests that arrive while busy are answered with accepted low.
module char_lcd_nibble_write_sequencer_unit #(
  parameter int TIMER_WIDTH = lcdnw_pkg::LCDNW_TIMER_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [0] rs, [8:1] byte_value, [15:9] zero
  input  logic        s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] rs_pin, [1] enable_pin, [5:2] data_nibble,
                                      // [6] busy_res, [7] accepted
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import lcdnw_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  item_take;

  assign in_item.command    = command_t'(s_axis_tuser);
  assign in_item.rs         = s_axis_tdata[0];
  assign in_item.byte_value = s_axis_tdata[8:1];

  lcdnw_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lcdnw_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  lcdnw_seq #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res_data   (m_axis_tdata)
  );

endmodule

/* src/lcdnw_checker.sv */
// Port-level checker of the LCD nibble write sequencer and its bind.
`timescale 1ns / 1ps
`include "char_lcd_nibble_write_sequencer_unit_defines.svh"

module lcdnw_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  `LCDNW_ASSERT(a_accept_busy, m_axis_tvalid && m_axis_tdata[7] |-> m_axis_tdata[6], "accepted write not shown busy")
  `LCDNW_ASSERT(a_accept_enable, m_axis_tvalid && m_axis_tdata[7] |-> m_axis_tdata[1], "accepted write without enable high")
  `LCDNW_ASSERT(a_idle_enable_low, m_axis_tvalid && !m_axis_tdata[6] |-> !m_axis_tdata[1], "enable high while idle")
  `LCDNW_ASSERT(a_result_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `LCDNW_ASSERT_ALWAYS(a_reset_clear, rst |=> !m_axis_tvalid, "result valid right after reset")

endmodule

bind char_lcd_nibble_write_sequencer_unit lcdnw_checker u_lcdnw_checker (.*);
